>>> design/sma_pkg.sv
`default_nettype none

package sma_pkg;

  localparam int PRICE_W        = 32;
  localparam int LEN_W          = 7;
  localparam int WINDOW_MAX_DEF = 64;

  typedef struct packed {
    logic start;
    logic neg;
  } sma_div_req_t;

endpackage

`default_nettype wire

>>> design/simple_moving_average.sv
// Moving average of signed Q16.16 samples over the last window_len samples
// (1 to WINDOW_MAX; zero acts as one, larger values saturate). A sample whose
// tuser bit is set starts a new series, and a write of window_len also empties
// the window. No mean is produced until the window holds window_len samples
// of the current series; each sample after that yields one mean, truncated
// toward zero. A sample that yields no mean passes through the summing state
// only. A sample that yields a mean then goes through the load, divide and
// finish states; the divide state lasts until the bit-serial divider, which
// produces one quotient bit per cycle, is done. A finished mean waits in
// the output register while the next sample is taken in. The window_len
// port is ready only while the block is idle.
`default_nettype none

module simple_moving_average #(
  parameter int WINDOW_MAX = sma_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [sma_pkg::PRICE_W-1:0]   in_tdata,  // price
  input  wire logic                          in_tuser,  // series_start
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [sma_pkg::PRICE_W-1:0]   out_tdata, // mean
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sma_pkg::LEN_W-1:0]     cfg_data   // window_len
);
  import sma_pkg::*;

  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W = PRICE_W + $clog2(WINDOW_MAX);
  localparam int CW    = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                state_r, state_nxt;
  logic [LEN_W-1:0]          len_r, len_nxt;
  logic [LEN_W-1:0]          fill_r, fill_nxt;
  logic [PTR_W-1:0]          ws_r, ws_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [PRICE_W-1:0]        out_tdata_r, out_tdata_nxt;
  logic signed [PRICE_W-1:0] price_r, price_nxt;
  logic                      need_sub_r, need_sub_nxt;

  logic                      in_acc;
  logic                      cfg_acc;
  logic [PTR_W-1:0]          ws_eff;
  logic [LEN_W-1:0]          fill_eff;
  logic [CW-1:0]             ws_ext;
  logic [CW-1:0]             len_ext;
  logic [CW-1:0]             old_calc;
  logic [PTR_W-1:0]          rd_addr;
  logic [PRICE_W-1:0]        rd_data;
  logic                      wr_en;
  logic signed [PRICE_W:0]   delta;
  logic [PRICE_W-1:0]        sub_val;
  logic [LEN_W-1:0]          fill_inc;
  logic [SUM_W-1:0]          sum_mag;
  sma_div_req_t              div_req;
  logic                      div_done;
  logic [PRICE_W-1:0]        div_q;

  // A pending configuration transaction takes precedence over a sample.
  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign ws_eff   = in_tuser ? '0 : ws_r;
  assign fill_eff = in_tuser ? '0 : fill_r;
  assign ws_ext   = CW'(ws_eff);
  assign len_ext  = CW'(len_r);
  assign old_calc = (ws_ext >= len_ext) ? (ws_ext - len_ext)
                                        : (ws_ext + CW'(WINDOW_MAX) - len_ext);
  assign rd_addr  = old_calc[PTR_W-1:0];

  assign sub_val  = need_sub_r ? rd_data : '0;
  assign delta    = (PRICE_W+1)'(price_r) - (PRICE_W+1)'($signed(sub_val));
  assign fill_inc = (fill_r < len_r) ? (fill_r + 1'b1) : fill_r;
  assign sum_mag  = sum_r[SUM_W-1] ? SUM_W'(0 - sum_r) : SUM_W'(sum_r);
  assign wr_en    = (state_r == S_SUM);

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    fill_nxt       = fill_r;
    ws_nxt         = ws_r;
    sum_nxt        = sum_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    price_nxt      = price_r;
    need_sub_nxt   = need_sub_r;
    div_req.start  = 1'b0;
    div_req.neg    = sum_r[SUM_W-1];

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          price_nxt    = $signed(in_tdata);
          need_sub_nxt = (fill_eff >= len_r);
          if (in_tuser) begin
            sum_nxt  = '0;
            fill_nxt = '0;
            ws_nxt   = '0;
          end
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt  = sum_r + SUM_W'(delta);
        fill_nxt = fill_inc;
        ws_nxt   = (ws_r == PTR_W'(WINDOW_MAX - 1)) ? '0 : (ws_r + 1'b1);
        state_nxt = (fill_inc == len_r) ? S_LOAD : S_IDLE;
      end
      S_LOAD: begin
        div_req.start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = div_q;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_acc) begin
      if (cfg_data == '0) begin
        len_nxt = LEN_W'(1);
      end else if (32'(cfg_data) > WINDOW_MAX) begin
        len_nxt = LEN_W'(WINDOW_MAX);
      end else begin
        len_nxt = cfg_data;
      end
      sum_nxt  = '0;
      fill_nxt = '0;
      ws_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      len_r        <= LEN_W'(1);
      fill_r       <= '0;
      ws_r         <= '0;
      sum_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      fill_r       <= fill_nxt;
      ws_r         <= ws_nxt;
      sum_r        <= sum_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    price_r     <= price_nxt;
    need_sub_r  <= need_sub_nxt;
  end

  sma_ring #(
    .DEPTH (WINDOW_MAX),
    .PTR_W (PTR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ws_r),
    .wr_data (price_r),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sma_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (sum_mag),
    .divisor  (len_r),
    .done     (div_done),
    .quotient (div_q)
  );

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_r)
    else $error("Fill count exceeds the window length.");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("Divider finished outside the divide state.");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> (fill_r == '0) && (sum_r == '0) && (ws_r == '0))
    else $error("Window not emptied after a configuration transaction.");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_FIN))
    else $error("Output became valid without a finished division.");

endmodule

`default_nettype wire

>>> design/sma_ring.sv
`default_nettype none

module sma_ring #(
  parameter int DEPTH = sma_pkg::WINDOW_MAX_DEF,
  parameter int PTR_W = 6
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [PTR_W-1:0]              wr_addr,
  input  wire logic [sma_pkg::PRICE_W-1:0]   wr_data,
  input  wire logic                          rd_en,
  input  wire logic [PTR_W-1:0]              rd_addr,
  output logic      [sma_pkg::PRICE_W-1:0]   rd_data
);
  import sma_pkg::*;

  logic [PRICE_W-1:0] mem [DEPTH];
  logic [PRICE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> design/sma_div.sv
`default_nettype none

module sma_div #(
  parameter int SUM_W = 38
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sma_pkg::sma_div_req_t        req,
  input  wire logic [SUM_W-1:0]             dividend,
  input  wire logic [sma_pkg::LEN_W-1:0]    divisor,
  output logic                              done,
  output logic      [sma_pkg::PRICE_W-1:0]  quotient
);
  import sma_pkg::*;

  localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [LEN_W:0]   trial;
  logic [LEN_W:0]   diff;
  logic             fits;
  logic [PRICE_W-1:0] q_low;

  // One quotient bit per cycle: restoring division of the magnitude.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[SUM_W-1]};
    diff     = trial - {1'b0, dvs_r};
    fits     = (trial >= {1'b0, dvs_r});
    if (req.start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      neg_nxt  = req.neg;
    end else if (busy_r) begin
      quo_nxt = {quo_r[SUM_W-2:0], fits};
      rem_nxt = fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign q_low    = quo_r[PRICE_W-1:0];
  assign quotient = neg_r ? (~q_low + 1'b1) : q_low;
  assign done     = done_r;

endmodule

`default_nettype wire

>>> verif/simple_moving_average_test.sv
`timescale 1ns / 1ps

module simple_moving_average_test;

  import sma_pkg::*;

  localparam int WINDOW_DEPTH = WINDOW_MAX_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               series_start;
  } price_tick_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [PRICE_W-1:0] in_tdata = '0;
  logic               in_tuser = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [PRICE_W-1:0] out_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LEN_W-1:0]   cfg_data = '0;

  price_tick_t        pending_ticks[$];
  logic [PRICE_W-1:0] expected_means[$];

  logic signed [PRICE_W-1:0] price_ring[WINDOW_DEPTH];
  logic signed [37:0]        window_sum;
  int unsigned               samples_held;
  int unsigned               next_slot;
  logic [LEN_W-1:0]          window_setting;

  bit idling_on = 1'b1;
  int send_gap = 0;
  int recv_gap = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  simple_moving_average dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned active_len();
    if (window_setting == 0) return 1;
    if (window_setting > WINDOW_DEPTH) return WINDOW_DEPTH;
    return 32'(window_setting);
  endfunction

  function automatic void clear_window();
    window_sum   = '0;
    samples_held = 0;
    next_slot    = 0;
  endfunction

  function automatic void take_sample(input logic signed [PRICE_W-1:0] price,
                                      input logic series_start);
    int unsigned        len;
    int unsigned        oldest;
    logic signed [37:0] divisor;
    logic signed [37:0] quotient;
    len = active_len();
    if (series_start) clear_window();
    if (samples_held >= len) begin
      oldest = (next_slot + WINDOW_DEPTH - len) % WINDOW_DEPTH;
      window_sum = window_sum - price_ring[oldest];
    end
    price_ring[next_slot] = price;
    window_sum = window_sum + price;
    next_slot = (next_slot + 1) % WINDOW_DEPTH;
    if (samples_held < len) samples_held++;
    if (samples_held == len) begin
      divisor  = 38'(len);
      quotient = window_sum / divisor;
      expected_means = {expected_means, quotient[PRICE_W-1:0]};
    end
  endfunction

  function automatic logic [PRICE_W-1:0] random_price();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // Input side: the transaction accepted at this edge goes to the predictor.
  always @(posedge clk) begin
    price_tick_t tick;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        take_sample(in_tdata, in_tuser);
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          if (idling_on && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 17) - 1;
            in_tvalid <= 1'b0;
          end else begin
            tick = pending_ticks.pop_front();
            in_tvalid <= 1'b1;
            in_tdata  <= tick.price;
            in_tuser  <= tick.series_start;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: every mean transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    logic [PRICE_W-1:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_means.size() == 0) begin
          $error("mean: unexpected result, actual %0d", $signed(out_tdata));
          mismatch_count++;
        end else begin
          want = expected_means.pop_front();
          if (out_tdata !== want) begin
            $error("mean mismatch: expected %0d, actual %0d", $signed(want),
                   $signed(out_tdata));
            mismatch_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 17) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_window(input logic [LEN_W-1:0] len);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    window_setting = len;
    clear_window();
  endtask

  task automatic queue_tick(input logic [PRICE_W-1:0] price, input logic series_start);
    price_tick_t tick;
    tick.price        = price;
    tick.series_start = series_start;
    pending_ticks = {pending_ticks, tick};
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() > 0 || in_tvalid || expected_means.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [LEN_W-1:0] settings[10];
    for (int i = 0; i < WINDOW_DEPTH; i++) price_ring[i] = '0;
    window_setting = 1;
    clear_window();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // A zero length acts as a window of one sample.
    write_window(0);
    queue_tick(32'h7FFF_FFFF, 1'b1);
    queue_tick(32'h8000_0000, 1'b0);
    queue_tick(32'h0000_0000, 1'b0);
    queue_tick(32'hFFFF_FFFF, 1'b0);
    wait_drained();

    // Extreme sums, a restart in mid-window, and truncation toward zero.
    write_window(3);
    repeat (3) queue_tick(32'h7FFF_FFFF, 1'b0);
    repeat (3) queue_tick(32'h8000_0000, 1'b0);
    queue_tick(32'hFFFF_FFFF, 1'b1);
    queue_tick(32'hFFFF_FFFF, 1'b0);
    queue_tick(32'hFFFF_FFFE, 1'b0);
    queue_tick(32'h0000_0005, 1'b1);
    queue_tick(32'h0000_0001, 1'b0);
    queue_tick(32'h0000_0001, 1'b0);
    wait_drained();

    settings[0] = 127;
    settings[1] = 64;
    settings[2] = 1;
    settings[3] = 2;
    settings[4] = LEN_W'($urandom_range(2, 16));
    settings[5] = 0;
    settings[6] = 65;
    settings[7] = LEN_W'($urandom_range(1, 127));
    settings[8] = 7;
    settings[9] = 33;
    for (int p = 0; p < 10; p++) begin
      idling_on = (p != 4) && (p != 9);
      write_window(settings[p]);
      for (int n = 0; n < 90; n++) begin
        queue_tick(random_price(), n == 0 || $urandom_range(0, 49) == 0);
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
